@@ hw/rtl/sstf_pkg.sv @@
// Shared types, constants and codes for the SSTF disk request scheduler.
// Used by the request queue, the scheduling engine and the top level.
// No dependencies.
package sstf_pkg;

    localparam int TABLE_DEPTH     = 16;
    localparam int MAX_REQUESTERS  = 16;
    localparam int DISTANCE_CUTOFF = 999;

    localparam int ID_W    = 4;
    localparam int TRACK_W = 10;
    localparam int CFG_W   = 5;
    localparam int FIN_W   = 5;
    localparam int FIN_MAX = (1 << FIN_W) - 1;

    localparam int OCC_W  = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RQ_W   = $clog2(MAX_REQUESTERS + 1);
    localparam int CUT_W  = $clog2(DISTANCE_CUTOFF + 1);
    localparam int BEST_W = (CUT_W > TRACK_W) ? CUT_W : TRACK_W;

    localparam logic KIND_SERVED  = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    localparam logic CFG_IDX_CAPACITY   = 1'b0;
    localparam logic CFG_IDX_REQUESTERS = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] track;
        logic               last;
    } request_t;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] track;
        logic               last;
        logic               done;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic       index;
        logic [CFG_W-1:0] data;
    } cfg_write_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REFUSE,
        ST_CHECK,
        ST_SCAN,
        ST_SERVE,
        ST_FINISH
    } eng_state_t;

endpackage

@@ hw/rtl/sstf_disk_request_scheduler.sv @@
// Shortest-seek-time-first disk request scheduler, top level.
// Channels: request input (valid/ready), result output (valid/ready) and a
// configuration write port (cfg_valid/cfg_ready, cfg_index, cfg_data).
// Index 0 sets queue capacity, index 1 the requester count; cfg_ready is
// always high.
// Requests land in a two-deep queue, so the input stays ready while the
// engine works or while a result waits at the output, until two are queued.
// Each request yields one refused result, nothing, or a run of services.
// A refusal passes through the queue slot, the hold register and the result register.
// A service checks the limit, scans the table one entry per cycle, serves
// and emits, in states ST_CHECK, ST_SCAN, ST_SERVE and ST_FINISH.
// A run ends with last_result set; all_done shows the state after each result.
// A stalled output holds the result; the engine waits before its next emit,
// and the queue fills and drops ready after two more requests.
// Reset: table empty, head at track 0, nothing finished, both config
// registers at 1. The table contents themselves are not cleared.
// Depends on sstf_pkg, sstf_req_queue and sstf_engine.
module sstf_disk_request_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sstf_pkg::ID_W-1:0]     requester_id,
    input  logic [sstf_pkg::TRACK_W-1:0]  track,
    input  logic                          final_request,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [sstf_pkg::ID_W-1:0]     served_requester,
    output logic [sstf_pkg::TRACK_W-1:0]  served_track,
    output logic                          last_result,
    output logic                          all_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [sstf_pkg::CFG_W-1:0]    cfg_data
);
    import sstf_pkg::*;

    request_t   in_req;
    request_t   q_req;
    logic       q_valid;
    logic       q_pop;
    result_t    res;
    cfg_write_t cfg;

    assign in_req.id    = requester_id;
    assign in_req.track = track;
    assign in_req.last  = final_request;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    sstf_req_queue u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req)
    );

    sstf_engine u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign kind             = res.kind;
    assign served_requester = res.id;
    assign served_track     = res.track;
    assign last_result      = res.last;
    assign all_done         = res.done;

endmodule

@@ hw/rtl/sstf_req_queue.sv @@
// Front end: two-deep request queue between the input channel and the engine.
// Depends on sstf_pkg.
module sstf_req_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sstf_pkg::request_t in_req,
    output logic              q_valid,
    input  logic              q_pop,
    output sstf_pkg::request_t q_req
);
    import sstf_pkg::*;

    request_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

@@ hw/rtl/sstf_engine.sv @@
// Back end: request table, SSTF scan, service sequencing and result register.
// Depends on sstf_pkg.
module sstf_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  sstf_pkg::cfg_write_t cfg,
    input  logic               q_valid,
    output logic               q_pop,
    input  sstf_pkg::request_t q_req,
    output logic               out_valid,
    input  logic               out_ready,
    output sstf_pkg::result_t  out_res
);
    import sstf_pkg::*;

    eng_state_t state_reg, state_next;

    request_t               table_reg [TABLE_DEPTH];
    logic [OCC_W-1:0]       occ_reg;
    logic [TRACK_W-1:0]     head_reg;
    logic [FIN_W-1:0]       fin_reg;
    logic [MAX_REQUESTERS-1:0] pend_reg;
    logic [CFG_W-1:0]       cap_reg;
    logic [CFG_W-1:0]       rcnt_reg;

    request_t               hold_reg;
    request_t               srv_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       pick_reg;
    logic [BEST_W-1:0]      best_reg;

    logic                   out_valid_reg;
    result_t                out_res_reg;

    logic [OCC_W-1:0]       cap_eff;
    logic [RQ_W-1:0]        req_eff;
    logic [RQ_W-1:0]        left;
    logic [OCC_W-1:0]       limit;
    logic                   done;
    logic                   more;
    logic                   refuse;
    logic                   out_free;
    logic                   scan_last;
    request_t               cur;
    logic [TRACK_W-1:0]     seek;
    logic                   better;

    logic do_pop, do_append, do_refuse_latch, do_scan_init, do_scan_step;
    logic do_serve, do_emit_refuse, do_emit_serve;

    // effective limit follows capacity, requester count and finished count
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = OCC_W'(1);
        end
        else if (int'(cap_reg) > TABLE_DEPTH)
        begin
            cap_eff = OCC_W'(TABLE_DEPTH);
        end
        else
        begin
            cap_eff = OCC_W'(cap_reg);
        end

        if (int'(rcnt_reg) > MAX_REQUESTERS)
        begin
            req_eff = RQ_W'(MAX_REQUESTERS);
        end
        else
        begin
            req_eff = RQ_W'(rcnt_reg);
        end

        done  = (int'(fin_reg) >= int'(req_eff));
        left  = done ? '0 : RQ_W'(int'(req_eff) - int'(fin_reg));
        limit = (int'(left) < int'(cap_eff)) ? OCC_W'(left) : cap_eff;
        more  = !done && (occ_reg != '0) && (occ_reg >= limit);

        refuse = done || (occ_reg >= cap_eff) || (int'(q_req.id) >= MAX_REQUESTERS)
                 || pend_reg[q_req.id];
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign cur       = table_reg[idx_reg];
    assign seek      = (cur.track >= head_reg) ? (cur.track - head_reg)
                                               : (head_reg - cur.track);
    assign better    = (BEST_W'(seek) < best_reg);
    assign scan_last = ((OCC_W'(idx_reg) + OCC_W'(1)) == occ_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = refuse ? ST_REFUSE : ST_CHECK;
                end
            end
            ST_REFUSE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = more ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = more ? ST_CHECK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        do_pop          = 1'b0;
        do_append       = 1'b0;
        do_refuse_latch = 1'b0;
        do_scan_init    = 1'b0;
        do_scan_step    = 1'b0;
        do_serve        = 1'b0;
        do_emit_refuse  = 1'b0;
        do_emit_serve   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                do_pop          = q_valid;
                do_append       = q_valid && !refuse;
                do_refuse_latch = q_valid && refuse;
            end
            ST_REFUSE:
            begin
                do_emit_refuse = out_free;
            end
            ST_CHECK:
            begin
                do_scan_init = more;
            end
            ST_SCAN:
            begin
                do_scan_step = 1'b1;
            end
            ST_SERVE:
            begin
                do_serve = 1'b1;
            end
            ST_FINISH:
            begin
                do_emit_serve = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign q_pop = do_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            head_reg      <= '0;
            fin_reg       <= '0;
            pend_reg      <= '0;
            cap_reg       <= CFG_W'(1);
            rcnt_reg      <= CFG_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_IDX_CAPACITY:   cap_reg  <= cfg.data;
                    CFG_IDX_REQUESTERS: rcnt_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end

            if (do_append)
            begin
                occ_reg            <= occ_reg + OCC_W'(1);
                pend_reg[q_req.id] <= 1'b1;
            end

            if (do_serve)
            begin
                occ_reg  <= occ_reg - OCC_W'(1);
                head_reg <= srv_reg.track;
                if (int'(srv_reg.id) < MAX_REQUESTERS)
                begin
                    pend_reg[srv_reg.id] <= 1'b0;
                end
                if (srv_reg.last && (int'(fin_reg) < FIN_MAX))
                begin
                    fin_reg <= fin_reg + FIN_W'(1);
                end
            end

            if (do_emit_refuse || do_emit_serve)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_refuse_latch)
        begin
            hold_reg <= q_req;
        end

        if (do_scan_init)
        begin
            idx_reg  <= '0;
            pick_reg <= '0;
            best_reg <= BEST_W'(DISTANCE_CUTOFF);
        end
        else if (do_scan_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            // oldest entry is the fallback when nothing beats the cutoff
            if (better || (idx_reg == '0))
            begin
                srv_reg <= cur;
            end
            if (better)
            begin
                best_reg <= BEST_W'(seek);
                pick_reg <= idx_reg;
            end
        end

        if (do_emit_refuse)
        begin
            out_res_reg.kind  <= KIND_REFUSED;
            out_res_reg.id    <= hold_reg.id;
            out_res_reg.track <= hold_reg.track;
            out_res_reg.last  <= 1'b1;
            out_res_reg.done  <= done;
        end
        else if (do_emit_serve)
        begin
            out_res_reg.kind  <= KIND_SERVED;
            out_res_reg.id    <= srv_reg.id;
            out_res_reg.track <= srv_reg.track;
            out_res_reg.last  <= !more;
            out_res_reg.done  <= done;
        end
    end

    // table entries: append at the tail, close the gap after a service
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < TABLE_DEPTH; g++)
        begin
            if (do_append && (occ_reg == OCC_W'(g)))
            begin
                table_reg[g] <= q_req;
            end
            else if (do_serve && (g >= int'(pick_reg)) && ((g + 1) < int'(occ_reg))
                     && (g < TABLE_DEPTH - 1))
            begin
                table_reg[g] <= table_reg[(g < TABLE_DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

@@ hw/rtl/sstf_checker.sv @@
// Port-level checks for the SSTF disk request scheduler, bound to the top.
// Depends on sstf_pkg and sstf_disk_request_scheduler.
module sstf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          kind,
    input logic [sstf_pkg::ID_W-1:0]     served_requester,
    input logic [sstf_pkg::TRACK_W-1:0]  served_track,
    input logic                          last_result,
    input logic                          all_done
);
    import sstf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable({kind, served_requester, served_track, last_result, all_done}))
        else $error("result changed while stalled");

    // a refusal never starts a service run
    a_refuse_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_REFUSED) |-> last_result)
        else $error("refused request not marked last");

    // a served result that leaves everyone done must close its run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SERVED) && all_done |-> last_result)
        else $error("service run continues after all requesters finished");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_chk (.*);
